@@ design/thermocouple_spi_reader_core_defines.svh @@
// Assertion macros shared by the thermocouple reader checker.
`ifndef THERMOCOUPLE_SPI_READER_CORE_DEFINES_SVH
`define THERMOCOUPLE_SPI_READER_CORE_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define TSR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked on every rising edge outside reset.
`define TSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/tsr_pkg.sv @@
// Types and constants of the thermocouple serial reader.
package tsr_pkg;

	// Last read status codes
	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_NO_RESPONSE = 3'd1,
		ST_STUCK_LOW   = 3'd2,
		ST_OPEN        = 3'd3,
		ST_NOT_READY   = 3'd4
	} status_t;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_ENABLED      = 2'd0;
	localparam logic [1:0] REG_HALF_PERIOD  = 2'd1;
	localparam logic [1:0] REG_MIN_INTERVAL = 2'd2;

	// Register widths and reset values
	localparam int HALF_W = 16;
	localparam int INTERVAL_W = 20;
	localparam logic [HALF_W-1:0] HALF_RESET = 16'd5;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 20'd220000;

	// Frame decoding
	localparam int FRAME_W = 16;
	localparam int TEMP_W = 12;
	localparam logic [FRAME_W-1:0] FRAME_ALL_ONES = 16'hFFFF;
	localparam logic [FRAME_W-1:0] FRAME_ALL_ZEROS = 16'h0000;
	localparam int OPEN_BIT = 2;
	localparam int TEMP_LSB = 3;

	// One tick in
	typedef struct packed {
		logic read_request;
		logic so_level;
	} in_item_t;

	// One result out
	typedef struct packed {
		logic              cs_level;
		logic              sck_level;
		logic              busy_res;
		logic              done_res;
		logic [2:0]        status;
		logic [TEMP_W-1:0] temperature;
		logic [FRAME_W-1:0] raw_word;
		logic              connected;
	} out_item_t;

endpackage

@@ design/tsr_stream_if.sv @@
// Valid/ready stream channel carrying one payload per transaction.
interface tsr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/thermocouple_spi_reader_core.sv @@
// Thermocouple serial reader: tick-driven CS/SCK sequencer and frame decoder.
//
// in_ch carries one microsecond tick per transaction (read_request, so_level).
// out_ch returns exactly one result per tick: the CS and SCK levels to drive
// after that tick, busy and done flags, the last status, last good
// temperature, last raw frame and the connected flag.
// Each tick is handled in one pass of logic between the tick and the result
// register, so one tick is taken every cycle unless the receiver stalls.
// The result register is the only buffer: in_ch.ready is high while it is
// empty or being drained, so a stalled receiver holds the result and stops
// new ticks; nothing is lost or repeated.
// Configuration (enabled, half period, minimum interval) is written over the
// APB port at byte addresses 0, 4 and 8; pready is tied high.
// Reset clears the sequencer to idle with CS high and SCK low, loads the
// register defaults (disabled, half period 5, interval 220000) and marks
// that no read has happened yet, so the first read skips the interval wait.
module thermocouple_spi_reader_core #(
	parameter int TIMER_WIDTH = 20,
	parameter int DELAY_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	tsr_stream_if.sink   in_ch,
	tsr_stream_if.source out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_WAIT  = 3'd1,
		PH_SETUP = 3'd2,
		PH_HIGH  = 3'd3,
		PH_LOW   = 3'd4
	} phase_t;

	localparam logic [TIMER_WIDTH-1:0] TimerMax = '1;
	localparam logic [32:0] DelayMax = (33'd1 << DELAY_WIDTH) - 33'd1;

	// Configuration registers
	logic                           enabled_q;
	logic [tsr_pkg::HALF_W-1:0]     half_q;
	logic [tsr_pkg::INTERVAL_W-1:0] min_q;

	// Sequencer state
	phase_t                      phase_q, phase_nx;
	logic [DELAY_WIDTH-1:0]      delay_q, delay_nx;
	logic [3:0]                  bit_q, bit_nx;
	logic [tsr_pkg::FRAME_W-1:0] shift_q, shift_nx;
	logic [TIMER_WIDTH-1:0]      since_q, since_nx, since_inc;
	logic                        has_read_q, has_read_nx;
	logic                        good_q, good_nx;
	tsr_pkg::status_t            status_q, status_nx;
	logic [tsr_pkg::TEMP_W-1:0]  temp_q, temp_nx;
	logic [tsr_pkg::FRAME_W-1:0] raw_q, raw_nx;
	logic                        done_nx;

	// Result register
	logic                out_valid_q;
	tsr_pkg::out_item_t  out_data_q, out_data_nx;

	logic                   accept;
	logic                   cfg_write;
	logic [32:0]            half_wide;
	logic [DELAY_WIDTH-1:0] eff_half;
	logic [DELAY_WIDTH:0]   delay_inc;
	logic                   delay_done;
	logic                   interval_ok;

	// Handshake: take a tick whenever the result register can move
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_data_q;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[3:2])
			tsr_pkg::REG_ENABLED:      prdata = {31'd0, enabled_q};
			tsr_pkg::REG_HALF_PERIOD:  prdata = 32'(half_q);
			tsr_pkg::REG_MIN_INTERVAL: prdata = 32'(min_q);
			default:                   prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			half_q <= tsr_pkg::HALF_RESET;
			min_q <= tsr_pkg::INTERVAL_RESET;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				tsr_pkg::REG_ENABLED:      enabled_q <= pwdata[0];
				tsr_pkg::REG_HALF_PERIOD:  half_q <= pwdata[tsr_pkg::HALF_W-1:0];
				tsr_pkg::REG_MIN_INTERVAL: min_q <= pwdata[tsr_pkg::INTERVAL_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the half period into the delay counter's range, zero counts as one
	always_comb begin
		half_wide = 33'(half_q);
		if (half_wide > DelayMax) begin
			half_wide = DelayMax;
		end
		if (half_wide == 33'd0) begin
			half_wide = 33'd1;
		end
		eff_half = half_wide[DELAY_WIDTH-1:0];
	end

	// Saturating interval timer and wait check
	assign since_inc = (since_q == TimerMax) ? since_q : since_q + 1'b1;
	assign interval_ok = !has_read_q || (33'(since_inc) >= 33'(min_q))
		|| (since_inc == TimerMax);

	assign delay_inc = (DELAY_WIDTH+1)'(delay_q) + 1'b1;
	assign delay_done = delay_inc >= (DELAY_WIDTH+1)'(eff_half);

	// Next state for one tick
	always_comb begin
		phase_nx = phase_q;
		delay_nx = delay_q;
		bit_nx = bit_q;
		shift_nx = shift_q;
		since_nx = since_inc;
		has_read_nx = has_read_q;
		good_nx = good_q;
		status_nx = status_q;
		temp_nx = temp_q;
		raw_nx = raw_q;
		done_nx = 1'b0;

		unique case (phase_q)
			PH_IDLE: begin
				if (in_ch.data.read_request) begin
					if (!enabled_q) begin
						status_nx = tsr_pkg::ST_NOT_READY;
						done_nx = 1'b1;
					end else if (interval_ok) begin
						phase_nx = PH_SETUP;
						delay_nx = '0;
						bit_nx = 4'd15;
						shift_nx = '0;
					end else begin
						phase_nx = PH_WAIT;
					end
				end
			end
			PH_WAIT: begin
				if (interval_ok) begin
					phase_nx = PH_SETUP;
					delay_nx = '0;
					bit_nx = 4'd15;
					shift_nx = '0;
				end
			end
			PH_SETUP, PH_HIGH, PH_LOW: begin
				delay_nx = delay_inc[DELAY_WIDTH-1:0];
				if (delay_done) begin
					delay_nx = '0;
					if (phase_q == PH_SETUP) begin
						phase_nx = PH_HIGH;
					end else if (phase_q == PH_HIGH) begin
						// sample SO on the last high tick
						shift_nx = shift_q
							| (tsr_pkg::FRAME_W'(in_ch.data.so_level) << bit_q);
						phase_nx = PH_LOW;
					end else if (bit_q == 4'd0) begin
						// frame complete: store and classify
						raw_nx = shift_q;
						if (shift_q == tsr_pkg::FRAME_ALL_ONES) begin
							status_nx = tsr_pkg::ST_NO_RESPONSE;
							good_nx = 1'b0;
						end else if (shift_q == tsr_pkg::FRAME_ALL_ZEROS) begin
							status_nx = tsr_pkg::ST_STUCK_LOW;
							good_nx = 1'b0;
						end else if (shift_q[tsr_pkg::OPEN_BIT]) begin
							status_nx = tsr_pkg::ST_OPEN;
							good_nx = 1'b0;
						end else begin
							status_nx = tsr_pkg::ST_OK;
							temp_nx = shift_q[tsr_pkg::TEMP_LSB +: tsr_pkg::TEMP_W];
							good_nx = 1'b1;
						end
						since_nx = '0;
						has_read_nx = 1'b1;
						phase_nx = PH_IDLE;
						done_nx = 1'b1;
					end else begin
						bit_nx = bit_q - 4'd1;
						phase_nx = PH_HIGH;
					end
				end
			end
			default: phase_nx = PH_IDLE;
		endcase
	end

	// Result built from the updated state
	always_comb begin
		out_data_nx.cs_level = !(phase_nx == PH_SETUP || phase_nx == PH_HIGH
			|| phase_nx == PH_LOW);
		out_data_nx.sck_level = (phase_nx == PH_HIGH);
		out_data_nx.busy_res = (phase_nx != PH_IDLE);
		out_data_nx.done_res = done_nx;
		out_data_nx.status = status_nx;
		out_data_nx.temperature = temp_nx;
		out_data_nx.raw_word = raw_nx;
		out_data_nx.connected = enabled_q && good_nx;
	end

	// Hold state and the result register; advance only on an accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			delay_q <= '0;
			bit_q <= 4'd15;
			shift_q <= '0;
			since_q <= '0;
			has_read_q <= 1'b0;
			good_q <= 1'b0;
			status_q <= tsr_pkg::ST_OK;
			temp_q <= '0;
			raw_q <= '0;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
		end else begin
			if (accept) begin
				phase_q <= phase_nx;
				delay_q <= delay_nx;
				bit_q <= bit_nx;
				shift_q <= shift_nx;
				since_q <= since_nx;
				has_read_q <= has_read_nx;
				good_q <= good_nx;
				status_q <= status_nx;
				temp_q <= temp_nx;
				raw_q <= raw_nx;
				out_valid_q <= 1'b1;
				out_data_q <= out_data_nx;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ design/tsr_checker.sv @@
// Port-level checker for the thermocouple reader and its bind.
`include "thermocouple_spi_reader_core_defines.svh"

module tsr_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input tsr_pkg::out_item_t         out_data
);

	// Stalled result holds
	`TSR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, $stable(out_data), "result changed under stall")

	// A finished read leaves the bus idle
	`TSR_ASSERT_IMPL(a_done_idle, out_valid && out_data.done_res, !out_data.busy_res && out_data.cs_level, "done while bus active")

	// SCK only pulses inside a frame
	`TSR_ASSERT_IMPL(a_sck_in_frame, out_valid && out_data.sck_level, !out_data.cs_level, "SCK high with CS high")

	// CS low means a read is under way
	`TSR_ASSERT_IMPL(a_cs_busy, out_valid && !out_data.cs_level, out_data.busy_res, "CS low while not busy")

endmodule

bind thermocouple_spi_reader_core tsr_checker u_tsr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);

@@ tb/sv/thermocouple_spi_reader_core_test.sv @@
// Self-checking testbench of the thermocouple serial reader core.
module thermocouple_spi_reader_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TIMER_W = 20;
	localparam int DELAY_W = 16;
	localparam int QUIET_LIMIT = 2000;

	// Sequencer phases tracked by the predictor
	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_WAIT,
		SEQ_SETUP,
		SEQ_HIGH,
		SEQ_LOW
	} seq_phase_t;

	// Predicts the per-tick outputs and checks them in order
	class tsr_scoreboard;
		logic                           enabled;
		logic [tsr_pkg::HALF_W-1:0]     half;
		logic [tsr_pkg::INTERVAL_W-1:0] min_interval;
		seq_phase_t                     phase;
		logic [DELAY_W-1:0]             delay_count;
		logic [3:0]                     bit_index;
		logic [tsr_pkg::FRAME_W-1:0]    shift_word;
		logic [TIMER_W-1:0]             since_last;
		logic                           has_read;
		logic                           sensor_good;
		tsr_pkg::status_t               last_status;
		logic [tsr_pkg::TEMP_W-1:0]     last_temp;
		logic [tsr_pkg::FRAME_W-1:0]    last_raw;
		tsr_pkg::out_item_t             pending_outputs[$];
		int                             errors;

		function new();
			enabled = 1'b0;
			half = tsr_pkg::HALF_RESET;
			min_interval = tsr_pkg::INTERVAL_RESET;
			phase = SEQ_IDLE;
			delay_count = '0;
			bit_index = 4'd15;
			shift_word = '0;
			since_last = '0;
			has_read = 1'b0;
			sensor_good = 1'b0;
			last_status = tsr_pkg::ST_OK;
			last_temp = '0;
			last_raw = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				tsr_pkg::REG_ENABLED:      enabled = val[0];
				tsr_pkg::REG_HALF_PERIOD:  half = val[tsr_pkg::HALF_W-1:0];
				tsr_pkg::REG_MIN_INTERVAL: min_interval = val[tsr_pkg::INTERVAL_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(logic [1:0] idx);
			case (idx)
				tsr_pkg::REG_ENABLED:      return {31'd0, enabled};
				tsr_pkg::REG_HALF_PERIOD:  return {{(32-tsr_pkg::HALF_W){1'b0}}, half};
				tsr_pkg::REG_MIN_INTERVAL:
					return {{(32-tsr_pkg::INTERVAL_W){1'b0}}, min_interval};
				default:                   return '0;
			endcase
		endfunction

		function bit interval_passed();
			return !has_read || since_last >= min_interval || since_last == '1;
		endfunction

		function void start_frame();
			phase = SEQ_SETUP;
			delay_count = '0;
			bit_index = 4'd15;
			shift_word = '0;
		endfunction

		// Advance the predicted state by one accepted tick
		function void note_tick(tsr_pkg::in_item_t t);
			tsr_pkg::out_item_t r;
			int h;
			bit done;
			h = (half == 0) ? 1 : int'(half);
			done = 1'b0;
			if (since_last != '1)
				since_last++;
			case (phase)
				SEQ_IDLE: begin
					if (t.read_request) begin
						if (!enabled) begin
							last_status = tsr_pkg::ST_NOT_READY;
							done = 1'b1;
						end else if (interval_passed()) begin
							start_frame();
						end else begin
							phase = SEQ_WAIT;
						end
					end
				end
				SEQ_WAIT: begin
					if (interval_passed())
						start_frame();
				end
				default: begin
					delay_count++;
					if (int'(delay_count) >= h) begin
						delay_count = '0;
						if (phase == SEQ_SETUP) begin
							phase = SEQ_HIGH;
						end else if (phase == SEQ_HIGH) begin
							shift_word[bit_index] = t.so_level;
							phase = SEQ_LOW;
						end else if (bit_index == 0) begin
							// classify the finished frame
							last_raw = shift_word;
							if (shift_word == tsr_pkg::FRAME_ALL_ONES) begin
								last_status = tsr_pkg::ST_NO_RESPONSE;
								sensor_good = 1'b0;
							end else if (shift_word == tsr_pkg::FRAME_ALL_ZEROS) begin
								last_status = tsr_pkg::ST_STUCK_LOW;
								sensor_good = 1'b0;
							end else if (shift_word[tsr_pkg::OPEN_BIT]) begin
								last_status = tsr_pkg::ST_OPEN;
								sensor_good = 1'b0;
							end else begin
								last_status = tsr_pkg::ST_OK;
								last_temp = shift_word[tsr_pkg::TEMP_LSB +: tsr_pkg::TEMP_W];
								sensor_good = 1'b1;
							end
							since_last = '0;
							has_read = 1'b1;
							phase = SEQ_IDLE;
							done = 1'b1;
						end else begin
							bit_index--;
							phase = SEQ_HIGH;
						end
					end
				end
			endcase
			r.cs_level = !(phase == SEQ_SETUP || phase == SEQ_HIGH || phase == SEQ_LOW);
			r.sck_level = (phase == SEQ_HIGH);
			r.busy_res = (phase != SEQ_IDLE);
			r.done_res = done;
			r.status = last_status;
			r.temperature = last_temp;
			r.raw_word = last_raw;
			r.connected = enabled && sensor_good;
			pending_outputs.push_back(r);
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= 10)
					$display("mismatch on %s: expected %h, got %h", field, want, got);
			end
		endfunction

		// Compare one result with the oldest prediction
		function void check_result(tsr_pkg::out_item_t got);
			tsr_pkg::out_item_t want;
			if (pending_outputs.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %h with nothing predicted", got);
				return;
			end
			want = pending_outputs.pop_front();
			compare_field("cs_level", want.cs_level, got.cs_level);
			compare_field("sck_level", want.sck_level, got.sck_level);
			compare_field("busy_res", want.busy_res, got.busy_res);
			compare_field("done_res", want.done_res, got.done_res);
			compare_field("status", want.status, got.status);
			compare_field("temperature", want.temperature, got.temperature);
			compare_field("raw_word", want.raw_word, got.raw_word);
			compare_field("connected", want.connected, got.connected);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	tsr_stream_if #(.payload_t(tsr_pkg::in_item_t)) in_ch ();
	tsr_stream_if #(.payload_t(tsr_pkg::out_item_t)) out_ch ();

	tsr_scoreboard sb = new();
	int burst_left = 0;
	int quiet_cycles = 0;

	thermocouple_spi_reader_core #(
		.TIMER_WIDTH(TIMER_W),
		.DELAY_WIDTH(DELAY_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	// Note accepted transactions and watch for a hang
	always @(posedge clk) begin : monitor
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (out_ch.valid && out_ch.ready) begin
				sb.check_result(out_ch.data);
				moved = 1'b1;
			end
			if (in_ch.valid && in_ch.ready) begin
				sb.note_tick(in_ch.data);
				moved = 1'b1;
			end
			if (moved || psel) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("thermocouple_spi_reader_core_test failed");
					$finish;
				end
			end
		end
	end

	// Stall the result channel in changing patterns
	initial begin : result_stall
		int rx_mode;
		int span;
		int stall_left;
		out_ch.ready = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			rx_mode = $urandom_range(0, 3);
			span = $urandom_range(50, 300);
			repeat (span) begin
				@(negedge clk);
				case (rx_mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= ($urandom_range(0, 3) != 0);
					2: out_ch.ready <= ($urandom_range(0, 3) == 0);
					default: begin
						if (stall_left > 0) begin
							stall_left--;
							out_ch.ready <= 1'b0;
						end else if ($urandom_range(0, 15) == 0) begin
							stall_left = $urandom_range(5, 24);
							out_ch.ready <= 1'b0;
						end else begin
							out_ch.ready <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	// Send one tick, opening a new burst after a random gap when due
	task automatic send_tick(input tsr_pkg::in_item_t t);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 64);
		end
		burst_left--;
		in_ch.valid <= 1'b1;
		in_ch.data <= t;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	// Hold off new ticks until every predicted result has come back
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.pending_outputs.size() != 0) @(negedge clk);
	endtask

	// Write a register, then read it back
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		logic [31:0] rd;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, val);
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.compare_field("register readback", sb.reg_value(idx), rd);
	endtask

	// Build the next tick; SO carries the wanted bit on the sampling tick unless noise is set
	function automatic tsr_pkg::in_item_t make_tick(input logic [15:0] word, input bit noise,
		input int req_pct);
		tsr_pkg::in_item_t t;
		int h;
		h = (sb.half == 0) ? 1 : int'(sb.half);
		t.read_request = ($urandom_range(0, 99) < req_pct);
		if (!noise && sb.phase == SEQ_HIGH && int'(sb.delay_count) + 1 >= h)
			t.so_level = word[sb.bit_index];
		else
			t.so_level = $urandom_range(0, 1);
		return t;
	endfunction

	function automatic logic [15:0] pick_word();
		logic [15:0] w;
		w = $urandom;
		case ($urandom_range(0, 7))
			0: w = tsr_pkg::FRAME_ALL_ONES;
			1: w = tsr_pkg::FRAME_ALL_ZEROS;
			2, 3: w[tsr_pkg::OPEN_BIT] = 1'b1;
			default: begin
				w[tsr_pkg::OPEN_BIT] = 1'b0;
				if (w == tsr_pkg::FRAME_ALL_ZEROS)
					w[tsr_pkg::TEMP_LSB] = 1'b1;
			end
		endcase
		return w;
	endfunction

	// Request one frame and tick until the sequencer is back to idle
	task automatic read_frame(input logic [15:0] word);
		send_tick(make_tick(word, 1'b0, 100));
		while (sb.phase != SEQ_IDLE) send_tick(make_tick(word, 1'b0, 25));
	endtask

	initial begin : stimulus
		logic [15:0] word;
		bit noise;
		int req_pct;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// requests while disabled get not-ready
		send_tick(tsr_pkg::in_item_t'{1'b1, 1'b0});
		send_tick(tsr_pkg::in_item_t'{1'b1, 1'b1});
		send_tick(tsr_pkg::in_item_t'{1'b0, 1'b1});
		drain();

		// first read after reset skips the default interval
		reg_write(tsr_pkg::REG_ENABLED, 32'd1);
		read_frame(16'h7FF8);

		// zero half period acts as one tick; cover each frame class
		drain();
		reg_write(tsr_pkg::REG_HALF_PERIOD, 32'd0);
		reg_write(tsr_pkg::REG_MIN_INTERVAL, 32'd0);
		read_frame(tsr_pkg::FRAME_ALL_ONES);
		read_frame(tsr_pkg::FRAME_ALL_ZEROS);
		read_frame(16'h1234);
		read_frame(16'h8000);
		read_frame(16'h0008);
		read_frame(tsr_pkg::FRAME_ALL_ONES);

		// back-to-back reads wait out the interval
		drain();
		reg_write(tsr_pkg::REG_MIN_INTERVAL, 32'd30);
		read_frame(16'h4F18);
		read_frame(16'h2A50);

		// disable while the read waits out the interval; the frame still runs and completes
		drain();
		reg_write(tsr_pkg::REG_HALF_PERIOD, 32'd3);
		send_tick(make_tick(16'h5550, 1'b0, 100));
		repeat (20) send_tick(make_tick(16'h5550, 1'b0, 0));
		drain();
		reg_write(tsr_pkg::REG_ENABLED, 32'd0);
		while (sb.phase != SEQ_IDLE) send_tick(make_tick(16'h5550, 1'b0, 30));
		send_tick(make_tick(16'h0, 1'b0, 100));

		// largest settings, no frame started under them
		drain();
		reg_write(tsr_pkg::REG_HALF_PERIOD, 32'hFFFF);
		reg_write(tsr_pkg::REG_MIN_INTERVAL, 32'hFFFFF);
		repeat (3) send_tick(make_tick(16'h0, 1'b0, 100));
		drain();
		reg_write(tsr_pkg::REG_ENABLED, 32'd1);
		repeat (3) send_tick(make_tick(16'h0, 1'b0, 0));

		// one slow frame
		drain();
		reg_write(tsr_pkg::REG_HALF_PERIOD, 32'd12);
		reg_write(tsr_pkg::REG_MIN_INTERVAL, 32'd0);
		read_frame(pick_word());

		// random phases, each with its own settings
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			case ($urandom_range(0, 4))
				0: reg_write(tsr_pkg::REG_HALF_PERIOD, 32'd0);
				1: reg_write(tsr_pkg::REG_HALF_PERIOD, 32'd1);
				2: reg_write(tsr_pkg::REG_HALF_PERIOD, 32'd2);
				default: reg_write(tsr_pkg::REG_HALF_PERIOD, $urandom_range(1, 4));
			endcase
			case ($urandom_range(0, 2))
				0: reg_write(tsr_pkg::REG_MIN_INTERVAL, 32'd0);
				1: reg_write(tsr_pkg::REG_MIN_INTERVAL, $urandom_range(1, 80));
				default: reg_write(tsr_pkg::REG_MIN_INTERVAL, $urandom_range(81, 400));
			endcase
			reg_write(tsr_pkg::REG_ENABLED,
				(ph == 2) ? 32'd0 : ($urandom_range(0, 7) != 0));
			case ($urandom_range(0, 2))
				0: req_pct = 5;
				1: req_pct = 20;
				default: req_pct = 50;
			endcase
			word = pick_word();
			noise = 1'b0;
			for (int i = 0; i < 150; i++) begin
				if (sb.phase == SEQ_IDLE) begin
					word = pick_word();
					noise = ($urandom_range(0, 7) == 0);
				end
				send_tick(make_tick(word, noise, req_pct));
				if ($urandom_range(0, 299) == 0)
					drain();
			end
		end

		// let the last results come back
		drain();
		repeat (4) @(negedge clk);
		if (sb.errors == 0)
			$display("thermocouple_spi_reader_core_test passed");
		else
			$display("thermocouple_spi_reader_core_test failed");
		$finish;
	end

endmodule
